[rtl/core/frc_pkg.sv]
// Shared types and constants for the filled-circle raster engine.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  // Built framebuffer size defaults
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] RESET_DIM = 7'd64;

  // Command codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Datapath widths
  localparam int COORD_W  = 11;  // signed box coordinates
  localparam int SQ_IN_W  = 9;   // signed offset fed to the squarer
  localparam int SQ_W     = 17;  // squared offset
  localparam int PIXEL_W  = 32;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_SETUP,
    ST_RADIUS,
    ST_ROW,
    ST_DY,
    ST_SCAN,
    ST_FLUSH,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

[rtl/core/frc_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module frc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: read data is registered and shows the old word during a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/core/frc_sq.sv]
// Shared squaring unit with registered result.
`timescale 1ns / 1ps
`default_nettype none

module frc_sq (
  input  wire logic                                clk,
  input  wire logic signed [frc_pkg::SQ_IN_W-1:0]  d,
  output logic             [frc_pkg::SQ_W-1:0]     sq
);

  logic signed [2*frc_pkg::SQ_IN_W-1:0] prod;

  // Square the offset; the result is never negative
  assign prod = d * d;

  always_ff @(posedge clk) begin
    sq <= prod[frc_pkg::SQ_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/core/filled_circle_raster_engine.sv]
// Filled-circle raster engine: framebuffer, draw sequencer and pixel read-back.
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_width (index 0)
// or image_height (index 1); cfg_ready is always high. Commands arrive on in_valid/in_ready
// and each gives one result on out_valid/out_ready with pixel_color and done_res.
// A read passes through a read address state and a read data state before its response.
// A draw sets up the clipped box and squares the radius, then for each row of the box
// squares the row offset, tests and writes one pixel per cycle through the shared squarer,
// and drains the write stage before the next row.
// One command is in work at a time; in_ready is high only while the sequencer is idle.
// After reset the framebuffer is cleared one word a cycle, all MAX_WIDTH * MAX_HEIGHT words
// (4096 at the defaults); no command is taken meanwhile, configuration writes are.
// The result sits in an output register: the next command is taken while it waits, and
// a finished command holds in its response state until the receiver frees that register.
`timescale 1ns / 1ps
`default_nettype none

module filled_circle_raster_engine #(
  parameter int MAX_WIDTH  = frc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = frc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              operation,
  input  wire logic signed [8:0]                 center_x,
  input  wire logic signed [8:0]                 center_y,
  input  wire logic [7:0]                        radius,
  input  wire logic [frc_pkg::PIXEL_W-1:0]       fill_color,
  input  wire logic [5:0]                        read_x,
  input  wire logic [5:0]                        read_y,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [frc_pkg::PIXEL_W-1:0]            pixel_color,
  output logic                                   done_res
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP  = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
  localparam int HCAP  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
  localparam int CW    = frc_pkg::COORD_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  frc_pkg::state_t state, state_next;

  logic [frc_pkg::CFG_DATA_W-1:0] image_width, image_height;
  logic [frc_pkg::CFG_DATA_W-1:0] w_clip, h_clip;

  // Latched command
  logic signed [CW-1:0]         cmd_cx, cmd_cy;
  logic [7:0]                   cmd_r;
  logic [frc_pkg::PIXEL_W-1:0]  cmd_color;
  logic [5:0]                   cmd_rx, cmd_ry;

  // Box and scan position
  logic signed [CW-1:0] r_ext, x_lo, x_hi, y_lo, y_hi;
  logic signed [CW-1:0] x0_c, x1_c, y0_c, y1_c;
  logic signed [CW-1:0] x, y, x0, x1, y1, x_inc, y_inc;
  logic signed [CW-1:0] dx_full, dy_full;
  logic                 box_empty;

  // Shared squarer and pixel test
  logic signed [frc_pkg::SQ_IN_W-1:0] sq_in;
  logic [frc_pkg::SQ_W-1:0]           sq_q;
  logic [15:0]                        r2;
  logic [frc_pkg::SQ_W-1:0]           dy2;
  logic [frc_pkg::SQ_W:0]             dist_sum;
  logic                               hit;

  // Memory side
  logic [AW-1:0]                clr_addr, row_base, p_addr, rd_addr, ram_addr;
  logic                         p_valid, rd_ok;
  logic                         ram_we;
  logic [frc_pkg::PIXEL_W-1:0]  ram_wdata, ram_rdata;
  logic [frc_pkg::PIXEL_W-1:0]  res_color;

  logic in_fire, out_free;

  assign cfg_ready = 1'b1;
  assign done_res  = 1'b1;
  assign in_ready  = (state == frc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Clip the image size to the built size
  assign w_clip = (image_width  > 7'(WCAP)) ? 7'(WCAP) : image_width;
  assign h_clip = (image_height > 7'(HCAP)) ? 7'(HCAP) : image_height;

  // Bounding box, upper edges exclusive
  assign r_ext = signed'({3'b000, cmd_r});
  assign x_lo  = cmd_cx - r_ext;
  assign x_hi  = cmd_cx + r_ext;
  assign y_lo  = cmd_cy - r_ext;
  assign y_hi  = cmd_cy + r_ext;
  assign x0_c  = (x_lo < 11'sd0) ? 11'sd0 : x_lo;
  assign y0_c  = (y_lo < 11'sd0) ? 11'sd0 : y_lo;
  assign x1_c  = (x_hi < signed'({4'b0000, w_clip})) ? x_hi : signed'({4'b0000, w_clip});
  assign y1_c  = (y_hi < signed'({4'b0000, h_clip})) ? y_hi : signed'({4'b0000, h_clip});
  assign box_empty = (x0_c >= x1_c) || (y0_c >= y1_c);

  assign x_inc   = x + 11'sd1;
  assign y_inc   = y + 11'sd1;
  assign dx_full = x - cmd_cx;
  assign dy_full = y - cmd_cy;

  // Pixel test on the registered square
  assign dist_sum = {1'b0, sq_q} + {1'b0, dy2};
  assign hit      = (dist_sum <= {2'b00, r2});

  // Read address; its range is checked in the read address state
  assign rd_addr = AW'(32'(cmd_ry) * MAX_WIDTH + 32'(cmd_rx));

  // Select the squarer operand
  always_comb begin
    case (state)
      frc_pkg::ST_SETUP:  sq_in = signed'({1'b0, cmd_r});
      frc_pkg::ST_RADIUS,
      frc_pkg::ST_ROW:    sq_in = dy_full[frc_pkg::SQ_IN_W-1:0];
      default:            sq_in = dx_full[frc_pkg::SQ_IN_W-1:0];
    endcase
  end

  frc_sq u_sq (
    .clk (clk),
    .d   (sq_in),
    .sq  (sq_q)
  );

  // Memory port: clearing pass, pixel write or read
  always_comb begin
    case (state)
      frc_pkg::ST_CLEAR:   ram_addr = clr_addr;
      frc_pkg::ST_RD_ADDR: ram_addr = rd_addr;
      default:             ram_addr = p_addr;
    endcase
  end

  assign ram_we    = (state == frc_pkg::ST_CLEAR) || (p_valid && hit);
  assign ram_wdata = (state == frc_pkg::ST_CLEAR) ? '0 : cmd_color;

  frc_ram #(
    .WIDTH (frc_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      frc_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = frc_pkg::ST_IDLE;
      end
      frc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (operation == frc_pkg::OP_READ) ? frc_pkg::ST_RD_ADDR
                                                       : frc_pkg::ST_SETUP;
        end
      end
      frc_pkg::ST_RD_ADDR: state_next = frc_pkg::ST_RD_DATA;
      frc_pkg::ST_RD_DATA: state_next = frc_pkg::ST_RESP;
      frc_pkg::ST_SETUP: begin
        state_next = box_empty ? frc_pkg::ST_RESP : frc_pkg::ST_RADIUS;
      end
      frc_pkg::ST_RADIUS:  state_next = frc_pkg::ST_DY;
      frc_pkg::ST_ROW:     state_next = frc_pkg::ST_DY;
      frc_pkg::ST_DY:      state_next = frc_pkg::ST_SCAN;
      frc_pkg::ST_SCAN: begin
        if (x_inc == x1) state_next = frc_pkg::ST_FLUSH;
      end
      frc_pkg::ST_FLUSH: begin
        state_next = (y_inc == y1) ? frc_pkg::ST_RESP : frc_pkg::ST_ROW;
      end
      frc_pkg::ST_RESP: begin
        if (out_free) state_next = frc_pkg::ST_IDLE;
      end
      default: state_next = frc_pkg::ST_IDLE;
    endcase
  end

  // Control registers: configuration, clearing pass, write stage, output
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= frc_pkg::RESET_DIM;
      image_height <= frc_pkg::RESET_DIM;
      clr_addr     <= '0;
      p_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          frc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          frc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (state == frc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      p_valid <= (state == frc_pkg::ST_SCAN);
      if (state == frc_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_cx    <= CW'(center_x);
      cmd_cy    <= CW'(center_y);
      cmd_r     <= radius;
      cmd_color <= fill_color;
      cmd_rx    <= read_x;
      cmd_ry    <= read_y;
    end
    case (state)
      frc_pkg::ST_RD_ADDR: begin
        rd_ok <= (32'(cmd_rx) < MAX_WIDTH) && (32'(cmd_ry) < MAX_HEIGHT);
      end
      frc_pkg::ST_RD_DATA: begin
        res_color <= rd_ok ? ram_rdata : '0;
      end
      frc_pkg::ST_SETUP: begin
        x0        <= x0_c;
        x1        <= x1_c;
        y1        <= y1_c;
        y         <= y0_c;
        res_color <= '0;
      end
      frc_pkg::ST_RADIUS: begin
        r2       <= sq_q[15:0];
        row_base <= AW'(32'(unsigned'(y[6:0])) * MAX_WIDTH);
      end
      frc_pkg::ST_DY: begin
        dy2 <= sq_q;
        x   <= x0;
      end
      frc_pkg::ST_SCAN: begin
        x      <= x_inc;
        p_addr <= row_base + AW'(unsigned'(x));
      end
      frc_pkg::ST_FLUSH: begin
        y        <= y_inc;
        row_base <= row_base + AW'(MAX_WIDTH);
      end
      frc_pkg::ST_RESP: begin
        if (out_free) pixel_color <= res_color;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Colour writes only come from the scan's write stage
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != frc_pkg::ST_CLEAR) |->
      (state == frc_pkg::ST_SCAN || state == frc_pkg::ST_FLUSH))
    else $error("pixel write outside the scan");

  // Scan column stays inside the clipped image
  a_scan_in_image: assert property (@(posedge clk) disable iff (rst)
    (state == frc_pkg::ST_SCAN) |->
      (x >= 11'sd0 && x < signed'({4'b0000, w_clip})))
    else $error("scan column outside the image");

  // Write stage address stays inside the framebuffer
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (32'(p_addr) < DEPTH))
    else $error("write address beyond the framebuffer");

  // Clearing pass ends in idle after the last word
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == frc_pkg::ST_CLEAR && clr_addr == LAST_ADDR) |=> (state == frc_pkg::ST_IDLE))
    else $error("clearing pass did not finish");
`endif

endmodule

`default_nettype wire
